### sv/mdm_pkg.sv
// Shared types and constants for the mecanum drive mixer with slew limit.
// No dependencies; every other file of the block but mdm_chk imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mdm_pkg;

    // Fixed item geometry
    localparam int WHEELS   = 4;
    localparam int AXES     = 3;
    localparam int IN_W     = 12;          // raw demand width
    localparam int AXIS_W   = IN_W + 1;    // demand after negation
    localparam int Q_W      = 16;          // Q4.12 gain / coefficient width
    localparam int TERM_W   = 30;          // gain * axis, signed
    localparam int MIX_W    = 31;          // sum of three terms, signed
    localparam int MUL_A_W  = 31;          // shared multiplier, signed operand
    localparam int MUL_P_W  = MUL_A_W + Q_W + 1;
    localparam int CMD_W    = 32;          // Q16.16 wheel command
    localparam int SLEW_W   = CMD_W + 2;
    localparam int DZ_W     = 11;
    localparam int GAIN_W   = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_GAINS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_GAINS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRAWL       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 3'd5;

    // Reset values and fixed coefficients
    localparam logic [GAIN_W-1:0] GAINS_ONE  = 48'h1000_1000_1000;
    localparam logic [Q_W-1:0]    Q_ONE      = 16'd4096;
    localparam logic [Q_W-1:0]    Q_HALF     = 16'd2048;
    localparam logic [SLEW_W-1:0] SLEW_SMALL = 34'd13107;  // 0.2 in Q16.16
    localparam logic [SLEW_W-1:0] SLEW_ZERO  = 34'd32768;  // 0.5 in Q16.16

    // Wheel order
    localparam logic [1:0] WHL_FL = 2'd0;
    localparam logic [1:0] WHL_FR = 2'd1;
    localparam logic [1:0] WHL_BR = 2'd2;
    localparam logic [1:0] WHL_BL = 2'd3;

    typedef struct packed {
        logic [GAIN_W-1:0] stick_gains;
        logic [GAIN_W-1:0] key_gains;
        logic [DZ_W-1:0]   deadzone;
        logic [Q_W-1:0]    boost;
        logic [Q_W-1:0]    crawl;
        logic [1:0]        invert;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AXIS_MUL,
        ST_AXIS_WR,
        ST_MIX,
        ST_WHL_MUL,
        ST_ROUND,
        ST_SLEW,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### sv/mdm_cfg.sv
// Configuration register file of the mixer: plain indexed write port.
// Depends on mdm_pkg for the register indexes and the t_cfg bundle.
`timescale 1ns / 1ps
`default_nettype none

module mdm_cfg
    import mdm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_index,
    input  wire logic [CFG_DAT_W-1:0] i_wdata,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // Register decode; unlisted indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stick_gains <= GAINS_ONE;
            r_cfg.key_gains   <= GAINS_ONE;
            r_cfg.deadzone    <= '0;
            r_cfg.boost       <= Q_ONE;
            r_cfg.crawl       <= Q_ONE;
            r_cfg.invert      <= '0;
        end else if (i_wr_en) begin
            unique case (i_index)
                CFG_STICK_GAINS: r_cfg.stick_gains <= i_wdata[GAIN_W-1:0];
                CFG_KEY_GAINS:   r_cfg.key_gains   <= i_wdata[GAIN_W-1:0];
                CFG_DEADZONE:    r_cfg.deadzone    <= i_wdata[DZ_W-1:0];
                CFG_BOOST:       r_cfg.boost       <= i_wdata[Q_W-1:0];
                CFG_CRAWL:       r_cfg.crawl       <= i_wdata[Q_W-1:0];
                CFG_INVERT:      r_cfg.invert      <= i_wdata[1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### sv/mdm_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
// Depends on mdm_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module mdm_mul
    import mdm_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic signed [MUL_A_W-1:0] i_a,
    input  wire logic        [Q_W-1:0]     i_b,
    output logic signed      [MUL_P_W-1:0] o_prod
);

    logic signed [MUL_P_W-1:0] r_prod;
    logic signed [Q_W:0]       w_b;

    // unsigned Q4.12 operand widened to a positive signed value
    assign w_b = signed'({1'b0, i_b});

    // both operands sign-extended to the full product width
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= MUL_P_W'(i_a) * MUL_P_W'(w_b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### sv/mecanum_drive_mixer_slew_core.sv
// Top level of the mecanum drive mixer with per-wheel slew limiting.
// Depends on mdm_pkg, mdm_cfg and mdm_mul.
//
// From acceptance to the result register, the three gain products and four
// coefficient products of a request all pass through the single shared
// multiplier (mdm_mul): each axis is multiplied and written back, each wheel
// is mixed, multiplied, rounded/saturated and slew clamped, and a last step
// hands over the result. s_axis_tready is high only while the sequencer is
// idle, so a new request is not taken until it is idle again. The result register
// lets a new request enter while the last result waits, and the sequencer
// holds in its final step if that result has still not been taken. Output
// commands are signed Q16.16, rounded half away from zero, saturated, then
// clamped to within 0.2 (or 0.5 for a zero command) of the previous command
// of the same wheel.
`timescale 1ns / 1ps
`default_nettype none

module mecanum_drive_mixer_slew_core
    import mdm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata,
    // request stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [39:0]          s_axis_tdata,  // forward, sideways, rotation, pad
    input  wire logic [2:0]           s_axis_tuser,  // kb_mode, shift_key, ctrl_key
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [127:0]              m_axis_tdata   // fl_cmd, fr_cmd,
                                                     // br_cmd, bl_cmd
);

    t_cfg   w_cfg;
    t_state r_state, n_state;

    logic signed [AXIS_W-1:0]  r_axis [AXES];
    logic signed [TERM_W-1:0]  r_term [AXES];
    logic signed [MIX_W-1:0]   r_mix;
    logic signed [CMD_W-1:0]   r_cmd;
    logic signed [CMD_W-1:0]   r_last [WHEELS];
    logic        [Q_W-1:0]     r_coeff;
    logic                      r_kb;
    logic        [1:0]         r_idx;
    logic                      r_out_valid;
    logic        [127:0]       r_out_data;

    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_mul_en;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic        [Q_W-1:0]     w_mul_b;
    logic signed [MUL_P_W-1:0] w_prod;
    logic        [GAIN_W-1:0]  w_gains;
    logic        [Q_W-1:0]     w_lane;
    logic signed [MIX_W-1:0]   w_mix;
    logic signed [AXIS_W-1:0]  w_fwd, w_side, w_rot;
    logic        [AXIS_W-1:0]  w_fwd_mag, w_side_mag;
    logic        [Q_W-1:0]     w_coeff;
    logic signed [CMD_W-1:0]   w_rounded;
    logic signed [CMD_W-1:0]   w_slewed;

    mdm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    mdm_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // Input conditioning: optional negation, stick-mode deadzone
    always_comb begin
        logic signed [AXIS_W-1:0] fwd_raw, side_raw;
        fwd_raw  = AXIS_W'(signed'(s_axis_tdata[11:0]));
        side_raw = AXIS_W'(signed'(s_axis_tdata[23:12]));
        w_rot    = AXIS_W'(signed'(s_axis_tdata[35:24]));
        w_fwd    = w_cfg.invert[1] ? -fwd_raw  : fwd_raw;
        w_side   = w_cfg.invert[0] ? -side_raw : side_raw;
        w_fwd_mag  = w_fwd[AXIS_W-1]  ? AXIS_W'(-w_fwd)  : AXIS_W'(w_fwd);
        w_side_mag = w_side[AXIS_W-1] ? AXIS_W'(-w_side) : AXIS_W'(w_side);
        if (!s_axis_tuser[0]) begin
            if (w_fwd_mag < AXIS_W'(w_cfg.deadzone))  w_fwd  = '0;
            if (w_side_mag < AXIS_W'(w_cfg.deadzone)) w_side = '0;
        end
    end

    // Speed coefficient; keys act only in keyboard mode
    always_comb begin
        if (!s_axis_tuser[0])     w_coeff = Q_ONE;
        else if (s_axis_tuser[1]) w_coeff = w_cfg.boost;
        else if (s_axis_tuser[2]) w_coeff = w_cfg.crawl;
        else                      w_coeff = Q_HALF;
    end

    // Gain lane of the axis in work
    assign w_gains = r_kb ? w_cfg.key_gains : w_cfg.stick_gains;
    always_comb begin
        case (r_idx)
            2'd0:    w_lane = w_gains[15:0];
            2'd1:    w_lane = w_gains[31:16];
            default: w_lane = w_gains[47:32];
        endcase
    end

    // Wheel mix of the registered axis terms
    always_comb begin
        logic signed [MIX_W-1:0] f, s, r;
        f = MIX_W'(r_term[0]);
        s = MIX_W'(r_term[1]);
        r = MIX_W'(r_term[2]);
        unique case (r_idx)
            WHL_FL:  w_mix = f - s - r;
            WHL_FR:  w_mix = -f - s - r;
            WHL_BR:  w_mix = -f + s - r;
            default: w_mix = f + s - r;
        endcase
    end

    // Q.24 to Q16.16: round half away from zero, saturate
    always_comb begin
        logic                 neg;
        logic [MUL_P_W-1:0]   mag;
        logic [MUL_P_W-1:0]   sum;
        logic [MUL_P_W-9:0]   q;
        neg = w_prod[MUL_P_W-1];
        mag = neg ? MUL_P_W'(-w_prod) : MUL_P_W'(w_prod);
        sum = mag + MUL_P_W'(128);
        q   = sum[MUL_P_W-1:8];
        if (neg) begin
            if (q > (MUL_P_W-8)'(33'h0_8000_0000)) w_rounded = 32'sh8000_0000;
            else w_rounded = CMD_W'(-signed'({1'b0, q}));
        end else begin
            if (q > (MUL_P_W-8)'(32'h7FFF_FFFF)) w_rounded = 32'sh7FFF_FFFF;
            else w_rounded = CMD_W'(q);
        end
    end

    // Slew clamp against the last command of this wheel
    always_comb begin
        logic signed [SLEW_W-1:0] cmd, old, step, hi, lo, res;
        cmd  = SLEW_W'(r_cmd);
        old  = SLEW_W'(r_last[r_idx]);
        step = (r_cmd != '0) ? signed'(SLEW_SMALL) : signed'(SLEW_ZERO);
        hi   = old + step;
        lo   = old - step;
        if (cmd > hi)      res = hi;
        else if (cmd < lo) res = lo;
        else               res = cmd;
        if (res > SLEW_W'(32'sh7FFF_FFFF))      w_slewed = 32'sh7FFF_FFFF;
        else if (res < SLEW_W'(32'sh8000_0000)) w_slewed = 32'sh8000_0000;
        else                                    w_slewed = CMD_W'(res);
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Sequencer next state and multiplier steering
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_mul_en      = 1'b0;
        w_mul_a       = MUL_A_W'(r_axis[r_idx]);
        w_mul_b       = w_lane;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) n_state = ST_AXIS_MUL;
            end
            ST_AXIS_MUL: begin
                w_mul_en = 1'b1;
                n_state  = ST_AXIS_WR;
            end
            ST_AXIS_WR: begin
                n_state = (r_idx == 2'(AXES - 1)) ? ST_MIX : ST_AXIS_MUL;
            end
            ST_MIX: begin
                n_state = ST_WHL_MUL;
            end
            ST_WHL_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_mix);
                w_mul_b  = r_coeff;
                n_state  = ST_ROUND;
            end
            ST_ROUND: begin
                n_state = ST_SLEW;
            end
            ST_SLEW: begin
                n_state = (r_idx == 2'(WHEELS - 1)) ? ST_DONE : ST_MIX;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_axis[0] <= w_fwd;
                    r_axis[1] <= w_side;
                    r_axis[2] <= w_rot;
                    r_coeff   <= w_coeff;
                    r_kb      <= s_axis_tuser[0];
                end
            end
            ST_AXIS_WR: r_term[r_idx] <= TERM_W'(w_prod);
            ST_MIX:     r_mix <= w_mix;
            ST_ROUND:   r_cmd <= w_rounded;
            default: ;
        endcase
    end

    // Step counter and wheel history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            for (int i = 0; i < WHEELS; i++) r_last[i] <= '0;
        end else begin
            case (r_state)
                ST_AXIS_WR: r_idx <= (r_idx == 2'(AXES - 1)) ? '0 : r_idx + 2'd1;
                ST_SLEW: begin
                    r_last[r_idx] <= w_slewed;
                    r_idx         <= r_idx + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_data <= {r_last[3], r_last[2], r_last[1], r_last[0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

### sv/mdm_chk.sv
// Port-level checker for the mecanum drive mixer, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module mdm_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_tvalid,
    input wire logic         i_s_tready,
    input wire logic         i_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [127:0] i_m_tdata
);

    // a request occupies the sequencer: no second request next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("request taken while sequencer busy");

    // a fresh result appears exactly as the sequencer returns to idle
    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> i_s_tready)
        else $error("result raised while sequencer not idle");

    // stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> i_m_tvalid)
        else $error("result dropped under back-pressure");

    // stalled result payload holds
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> $stable(i_m_tdata))
        else $error("result payload changed under back-pressure");

endmodule

bind mecanum_drive_mixer_slew_core mdm_chk u_mdm_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

`default_nettype wire

### sim/wheel_cmd_checker.sv
// Checker for the mecanum drive mixer: tracks register writes, predicts the four
// wheel commands of every accepted request and compares them with the results.
// Depends on mdm_pkg for widths, register indexes, slew steps and the config struct.
`timescale 1ns / 1ps

module wheel_cmd_checker
    import mdm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DAT_W-1:0]      i_cfg_wdata,
    input  logic                      i_req_valid,
    input  logic                      i_req_ready,
    input  logic [39:0]               i_req_data,   // forward, sideways, rotation, pad
    input  logic [2:0]                i_req_user,   // kb_mode, shift_key, ctrl_key
    input  logic                      i_rsp_valid,
    input  logic                      i_rsp_ready,
    input  logic [WHEELS*CMD_W-1:0]   i_rsp_data,   // fl_cmd, fr_cmd,
                                                    // br_cmd, bl_cmd
    output int                        o_errors,
    output int                        o_pending
);

    localparam longint CMD_MAX = 64'sd2147483647;
    localparam longint CMD_MIN = -64'sd2147483648;

    t_cfg                    cfg;
    longint                  prev_wheel_cmd [WHEELS];
    logic [WHEELS*CMD_W-1:0] wheel_cmds_due [$];

    function automatic longint clamp_s32(input longint v);
        if (v > CMD_MAX) return CMD_MAX;
        if (v < CMD_MIN) return CMD_MIN;
        return v;
    endfunction

    // Mix, scale, round and slew-limit one request; updates the per-wheel history
    function automatic logic [WHEELS*CMD_W-1:0] predict_wheel_cmds(
        input logic [IN_W-1:0] fwd_in,
        input logic [IN_W-1:0] side_in,
        input logic [IN_W-1:0] rot_in,
        input logic            kb,
        input logic            shift,
        input logic            ctrl
    );
        longint                  fwd, side, rot, dz, f, s, r, coeff, cmd, mag, step;
        longint                  mix [WHEELS];
        logic [GAIN_W-1:0]       gains;
        logic [WHEELS*CMD_W-1:0] cmds;

        fwd   = longint'(signed'(fwd_in));
        side  = longint'(signed'(side_in));
        rot   = longint'(signed'(rot_in));
        gains = kb ? cfg.key_gains : cfg.stick_gains;

        if (cfg.invert[0]) side = -side;
        if (cfg.invert[1]) fwd = -fwd;

        // stick deadzone: magnitude equal to the threshold still passes
        if (!kb) begin
            dz = longint'(cfg.deadzone);
            if (fwd > -dz && fwd < dz) fwd = 0;
            if (side > -dz && side < dz) side = 0;
        end

        f = longint'(gains[0*Q_W +: Q_W]) * fwd;
        s = longint'(gains[1*Q_W +: Q_W]) * side;
        r = longint'(gains[2*Q_W +: Q_W]) * rot;

        // speed keys only act in keyboard mode
        if (kb && shift)     coeff = longint'(cfg.boost);
        else if (kb && ctrl) coeff = longint'(cfg.crawl);
        else if (kb)         coeff = longint'(Q_HALF);
        else                 coeff = longint'(Q_ONE);

        mix[WHL_FL] = f - s - r;
        mix[WHL_FR] = -(f + s + r);
        mix[WHL_BR] = -(f - s + r);
        mix[WHL_BL] = f + s - r;

        for (int i = 0; i < WHEELS; i++) begin
            // Q.24 to Q16.16, half away from zero, then saturate
            cmd = mix[i] * coeff;
            mag = (cmd < 0) ? -cmd : cmd;
            mag = (mag + 128) >>> 8;
            cmd = clamp_s32((cmd < 0) ? -mag : mag);
            // slew clamp against the last command of this wheel
            step = (cmd != 0) ? longint'(SLEW_SMALL) : longint'(SLEW_ZERO);
            if (cmd > prev_wheel_cmd[i] + step)      cmd = prev_wheel_cmd[i] + step;
            else if (cmd < prev_wheel_cmd[i] - step) cmd = prev_wheel_cmd[i] - step;
            cmd = clamp_s32(cmd);
            prev_wheel_cmd[i] = cmd;
            cmds[i*CMD_W +: CMD_W] = cmd[CMD_W-1:0];
        end
        return cmds;
    endfunction

    // Everything is sampled at the rising edge
    always @(posedge i_clk) begin : sample
        logic [WHEELS*CMD_W-1:0] want;
        logic [CMD_W-1:0]        got_cmd;
        logic [CMD_W-1:0]        want_cmd;

        if (!i_rst_n) begin
            cfg.stick_gains = GAINS_ONE;
            cfg.key_gains   = GAINS_ONE;
            cfg.deadzone    = '0;
            cfg.boost       = Q_ONE;
            cfg.crawl       = Q_ONE;
            cfg.invert      = '0;
            for (int i = 0; i < WHEELS; i++) prev_wheel_cmd[i] = 0;
            wheel_cmds_due.delete();
        end else begin
            // register writes; upper bits and unused indexes are dropped
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_STICK_GAINS: cfg.stick_gains = i_cfg_wdata[GAIN_W-1:0];
                    CFG_KEY_GAINS:   cfg.key_gains   = i_cfg_wdata[GAIN_W-1:0];
                    CFG_DEADZONE:    cfg.deadzone    = i_cfg_wdata[DZ_W-1:0];
                    CFG_BOOST:       cfg.boost       = i_cfg_wdata[Q_W-1:0];
                    CFG_CRAWL:       cfg.crawl       = i_cfg_wdata[Q_W-1:0];
                    CFG_INVERT:      cfg.invert      = i_cfg_wdata[1:0];
                    default: ;
                endcase
            end

            // result side: compare against the oldest prediction
            if (i_rsp_valid && i_rsp_ready) begin
                if (wheel_cmds_due.size() == 0) begin
                    $display("%0t: result with no request pending: %h", $time, i_rsp_data);
                    o_errors = o_errors + 1;
                end else begin
                    want = wheel_cmds_due.pop_front();
                    for (int i = 0; i < WHEELS; i++) begin
                        want_cmd = want[i*CMD_W +: CMD_W];
                        got_cmd  = i_rsp_data[i*CMD_W +: CMD_W];
                        if (got_cmd !== want_cmd) begin
                            $display("%0t: wheel %0d command: expected %0d, got %0d",
                                     $time, i, $signed(want_cmd), $signed(got_cmd));
                            o_errors = o_errors + 1;
                        end
                    end
                end
            end

            // request side
            if (i_req_valid && i_req_ready) begin
                wheel_cmds_due.push_back(predict_wheel_cmds(
                    i_req_data[0*IN_W +: IN_W], i_req_data[1*IN_W +: IN_W],
                    i_req_data[2*IN_W +: IN_W],
                    i_req_user[0], i_req_user[1], i_req_user[2]));
            end
        end
        o_pending = wheel_cmds_due.size();
    end

endmodule

### sim/tb_top.sv
// Testbench top for mecanum_drive_mixer_slew_core: clock, reset, register writes,
// request and result stream traffic, and the final verdict.
// Depends on mdm_pkg, the block's RTL and wheel_cmd_checker.
`timescale 1ns / 1ps

module tb_top;
    import mdm_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 250;
    localparam int MODE_ITEMS   = 64;
    localparam int TAIL_CYCLES  = 40;

    // indexes past the last register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // tuser bits
    localparam logic [2:0] KEY_NONE  = 3'b000;
    localparam logic [2:0] KEY_KB    = 3'b001;
    localparam logic [2:0] KEY_SHIFT = 3'b010;
    localparam logic [2:0] KEY_CTRL  = 3'b100;

    // idling modes
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef enum {SET_TYPICAL, SET_MAX, SET_ZERO, SET_WILD} t_cfg_set;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index   = '0;
    logic [CFG_DAT_W-1:0]     i_cfg_wdata   = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [39:0]              s_axis_tdata  = '0;  // forward, sideways, rotation, pad
    logic [2:0]               s_axis_tuser  = '0;  // kb_mode, shift_key, ctrl_key
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [WHEELS*CMD_W-1:0]  m_axis_tdata;        // fl_cmd, fr_cmd,
                                                   // br_cmd, bl_cmd

    int   errors;
    int   pending;
    int   idle_mode = IDLE_NONE;
    logic hold_req  = 1'b0;
    int   hold_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    mecanum_drive_mixer_slew_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    wheel_cmd_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Result side: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin : result_sink
        int pct;
        pct = (idle_mode == IDLE_RECV) ? 75 : (idle_mode == IDLE_BOTH) ? 16 : 0;
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= pct);
        end
    end

    // Offer one request, with random gaps, and return at the accepting edge
    task automatic send_request(input logic [IN_W-1:0] fwd, input logic [IN_W-1:0] side,
                                input logic [IN_W-1:0] rot, input logic [2:0] keys);
        int pct;
        pct = (idle_mode == IDLE_SEND) ? 75 : (idle_mode == IDLE_BOTH) ? 16 : 0;
        @(negedge i_clk);
        while ($urandom_range(99) < pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, rot, side, fwd};
        s_axis_tuser  <= keys;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CFG_DAT_W-1:0] wide_random();
        return CFG_DAT_W'({$urandom(), $urandom()});
    endfunction

    // field value with random garbage above the register width
    function automatic logic [CFG_DAT_W-1:0] with_junk(input logic [CFG_DAT_W-1:0] value,
                                                       input int width);
        logic [CFG_DAT_W-1:0] junk;
        junk = wide_random();
        return (junk << width) | value;
    endfunction

    // three Q4.12 lanes in a useful range (0 to 2.0)
    function automatic logic [GAIN_W-1:0] typical_gains();
        return {Q_W'($urandom_range(8192)), Q_W'($urandom_range(8192)),
                Q_W'($urandom_range(8192))};
    endfunction

    function automatic logic [IN_W-1:0] random_axis();
        case ($urandom_range(9))
            0:       return '0;
            1:       return {1'b1, {(IN_W-1){1'b0}}};
            2:       return {1'b0, {(IN_W-1){1'b1}}};
            3, 4:    return IN_W'(int'($urandom_range(64)) - 32);
            default: return IN_W'($urandom());
        endcase
    endfunction

    task automatic apply_cfg_set(input t_cfg_set kind);
        case (kind)
            SET_MAX: begin
                write_reg(CFG_STICK_GAINS, '1);
                write_reg(CFG_KEY_GAINS, '1);
                write_reg(CFG_DEADZONE, '1);
                write_reg(CFG_BOOST, '1);
                write_reg(CFG_CRAWL, '1);
                write_reg(CFG_INVERT, '1);
            end
            SET_ZERO: begin
                write_reg(CFG_STICK_GAINS, '0);
                write_reg(CFG_KEY_GAINS, '0);
                write_reg(CFG_DEADZONE, '0);
                write_reg(CFG_BOOST, '0);
                write_reg(CFG_CRAWL, '0);
                write_reg(CFG_INVERT, '0);
            end
            SET_WILD: begin
                write_reg(CFG_STICK_GAINS, wide_random());
                write_reg(CFG_KEY_GAINS, wide_random());
                write_reg(CFG_DEADZONE, wide_random());
                write_reg(CFG_BOOST, wide_random());
                write_reg(CFG_CRAWL, wide_random());
                write_reg(CFG_INVERT, wide_random());
            end
            default: begin
                write_reg(CFG_STICK_GAINS, typical_gains());
                write_reg(CFG_KEY_GAINS, typical_gains());
                write_reg(CFG_DEADZONE, with_junk($urandom_range(200), DZ_W));
                write_reg(CFG_BOOST, with_junk($urandom_range(12288), Q_W));
                write_reg(CFG_CRAWL, with_junk($urandom_range(4096), Q_W));
                write_reg(CFG_INVERT, with_junk($urandom_range(3), 2));
            end
        endcase
        // writes past the last register must change nothing
        write_reg(CFG_SPARE_A, wide_random());
        write_reg(CFG_SPARE_B, wide_random());
    endtask

    // Run limit
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        t_cfg_set plan [6];
        plan = '{SET_TYPICAL, SET_MAX, SET_ZERO, SET_TYPICAL, SET_WILD, SET_TYPICAL};

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: extremes, modes and speed keys
        send_request('0, '0, '0, KEY_NONE);
        send_request(IN_W'(2047), IN_W'(2047), IN_W'(2047), KEY_NONE);
        send_request(IN_W'(-2048), IN_W'(-2048), IN_W'(-2048), KEY_NONE);
        send_request(IN_W'(2047), IN_W'(-2048), '0, KEY_SHIFT | KEY_CTRL);  // keys ignored
        send_request('0, '0, '0, KEY_NONE);                               // zero-command slew
        send_request(IN_W'(1000), '0, '0, KEY_KB);                         // half speed
        send_request(IN_W'(1000), '0, '0, KEY_KB | KEY_SHIFT);
        send_request(IN_W'(1000), '0, '0, KEY_KB | KEY_CTRL);
        send_request(IN_W'(1000), '0, '0, KEY_KB | KEY_SHIFT | KEY_CTRL);  // shift wins
        send_request('0, IN_W'(-2048), IN_W'(2047), KEY_KB);
        send_request(IN_W'(-1), IN_W'(1), IN_W'(-1), KEY_NONE);
        drain();

        // inverted axes, deadzone edge and saturating gains
        write_reg(CFG_INVERT, with_junk(3, 2));
        write_reg(CFG_DEADZONE, with_junk(100, DZ_W));
        write_reg(CFG_BOOST, '1);
        write_reg(CFG_CRAWL, '0);
        write_reg(CFG_KEY_GAINS, '1);
        write_reg(CFG_STICK_GAINS, GAINS_ONE);
        write_reg(CFG_SPARE_A, wide_random());
        send_request(IN_W'(-2048), IN_W'(-2048), IN_W'(5), KEY_NONE);     // negated minimum
        send_request(IN_W'(100), IN_W'(-100), '0, KEY_NONE);               // on the edge
        send_request(IN_W'(99), IN_W'(-99), IN_W'(7), KEY_NONE);           // inside
        send_request(IN_W'(-100), IN_W'(100), '0, KEY_NONE);
        send_request(IN_W'(99), IN_W'(99), IN_W'(-2048), KEY_KB);          // no deadzone
        send_request(IN_W'(2047), IN_W'(2047), IN_W'(2047), KEY_KB | KEY_SHIFT);
        send_request(IN_W'(-2048), IN_W'(-2048), IN_W'(-2048), KEY_KB | KEY_CTRL);
        send_request('0, '0, '0, KEY_KB);
        drain();

        // random phases, each under its own register settings
        for (int p = 0; p < 6; p++) begin
            apply_cfg_set(plan[p]);
            @(posedge i_clk);
            if (p == 0) hold_req = 1'b1;   // fill the block while results are held
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_mode = (n / MODE_ITEMS) % 4;
                if ($urandom_range(7) == 0)
                    send_request('0, '0, '0, 3'($urandom()));
                else
                    send_request(random_axis(), random_axis(), random_axis(),
                                 3'($urandom()));
            end
            drain();
            idle_mode = IDLE_NONE;
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
